### src/searchable_compacting_list_assert.svh
// Assertion macros for the searchable compacting list.
`ifndef SEARCHABLE_COMPACTING_LIST_ASSERT_SVH
`define SEARCHABLE_COMPACTING_LIST_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCL_ASSERT_IMPL(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define SCL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define SCL_ASSERT_IMPL(label, clk, rst, cond)
`define SCL_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### src/scl_pkg.sv
// Shared types and codes for the searchable compacting list.
package scl_pkg;
   // Number of entries the list can hold.
   localparam int LIST_DEPTH = 64;

   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_FIND    = 3'd1;
   localparam logic [2:0] OP_REPLACE = 3'd2;
   localparam logic [2:0] OP_DELETE  = 3'd3;
   localparam logic [2:0] OP_WRITE   = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BAD_POS   = 2'd3;

   // One accepted request as it travels from the front to the back.
   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] value;
      logic [31:0] new_value;
      logic [5:0]  position;
   } req_type;

   // One finished result.
   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  found_index;
      logic [31:0] read_data;
      logic [6:0]  entry_count;
   } rsp_type;
endpackage

### src/scl_fifo.sv
// Small two-entry queue used between the front, the back and the result port.
module scl_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = fill_ff == 2'd2;
   assign empty    = fill_ff == 2'd0;
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill updates.
   always_comb begin
      wr_in   = do_push ? ~wr_ff : wr_ff;
      rd_in   = do_pop ? ~rd_ff : rd_ff;
      fill_in = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (do_push) slot_ff[wr_ff] <= push_data;
   end
endmodule

### src/scl_engine.sv
// Back end: walks the entry memory one address per cycle to carry out a request.
module scl_engine #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  scl_pkg::req_type    cmd,
   output logic                cmd_take,
   output logic                res_push,
   output scl_pkg::rsp_type    res,
   input  logic                res_full,
   output logic [CW-1:0]       count_out
);
   import scl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHIFT, S_READ, S_DONE
   } state_type;

   logic [31:0]   mem [DEPTH];
   logic [31:0]   rdata_ff;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [31:0]   wdata;

   state_type     state_ff;
   req_type       cmd_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] ptr_ff;     // address whose data arrives this cycle
   logic          primed_ff;  // read data for ptr_ff is valid
   rsp_type       res_ff;
   logic [CW-1:0] pos_ext;

   assign count_out = count_ff;
   assign cmd_take  = state_ff == S_IDLE && cmd_valid;
   assign res_push  = state_ff == S_DONE && !res_full;
   assign res       = res_ff;
   assign pos_ext   = CW'(cmd.position);

   // Read address: next entry during a walk, the position for a read.
   always_comb begin
      if (state_ff == S_IDLE) raddr = cmd.opcode == OP_READ ? AW'(cmd.position) : '0;
      else if (primed_ff) raddr = AW'(ptr_ff + 1'b1);
      else raddr = AW'(ptr_ff);
   end

   // Memory writes: append, write at, replace and shift steps.
   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = cmd.value;
      if (state_ff == S_IDLE && cmd_valid) begin
         if (cmd.opcode == OP_APPEND && count_ff < CW'(DEPTH)) begin
            we = 1'b1;
            waddr = AW'(count_ff);
         end else if (cmd.opcode == OP_WRITE && pos_ext < count_ff) begin
            we = 1'b1;
            waddr = cmd.position;
         end
      end else if (state_ff == S_SCAN && primed_ff && ptr_ff < count_ff
                   && rdata_ff == cmd_ff.value && cmd_ff.opcode == OP_REPLACE) begin
         we = 1'b1;
         waddr = AW'(ptr_ff);
         wdata = cmd_ff.new_value;
      end else if (state_ff == S_SHIFT && primed_ff && ptr_ff < count_ff) begin
         we = 1'b1;
         waddr = AW'(ptr_ff - 1'b1);
         wdata = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ptr_ff    <= '0;
         primed_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cmd_ff    <= cmd;
               ptr_ff    <= '0;
               primed_ff <= 1'b1;
               case (cmd.opcode)
                  OP_APPEND: begin
                     if (count_ff < CW'(DEPTH)) begin
                        res_ff   <= '{ST_OK, 6'(count_ff), '0, count_ff + 1'b1};
                        count_ff <= count_ff + 1'b1;
                     end else res_ff <= '{ST_FULL, '0, '0, count_ff};
                     state_ff <= S_DONE;
                  end
                  OP_FIND, OP_REPLACE, OP_DELETE: state_ff <= S_SCAN;
                  OP_WRITE: begin
                     if (pos_ext < count_ff)
                        res_ff <= '{ST_OK, cmd.position, '0, count_ff};
                     else res_ff <= '{ST_BAD_POS, '0, '0, count_ff};
                     state_ff <= S_DONE;
                  end
                  OP_READ: begin
                     if (pos_ext < count_ff) state_ff <= S_READ;
                     else begin
                        res_ff   <= '{ST_BAD_POS, '0, '0, count_ff};
                        state_ff <= S_DONE;
                     end
                  end
                  default: begin
                     res_ff   <= '{ST_OK, '0, '0, count_ff};
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_READ: begin
               res_ff   <= '{ST_OK, cmd_ff.position, rdata_ff, count_ff};
               state_ff <= S_DONE;
            end
            S_SCAN: begin
               if (ptr_ff >= count_ff) begin
                  res_ff   <= '{ST_NOT_FOUND, '0, '0, count_ff};
                  state_ff <= S_DONE;
               end else if (rdata_ff == cmd_ff.value) begin
                  if (cmd_ff.opcode == OP_DELETE) begin
                     res_ff    <= '{ST_OK, 6'(ptr_ff), '0, count_ff - 1'b1};
                     ptr_ff    <= ptr_ff + 1'b1;
                     primed_ff <= 1'b1;
                     state_ff  <= S_SHIFT;
                  end else begin
                     res_ff   <= '{ST_OK, 6'(ptr_ff), '0, count_ff};
                     state_ff <= S_DONE;
                  end
               end else ptr_ff <= ptr_ff + 1'b1;
            end
            S_SHIFT: begin
               if (ptr_ff >= count_ff) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_DONE;
               end else ptr_ff <= ptr_ff + 1'b1;
            end
            S_DONE: if (!res_full) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### src/searchable_compacting_list.sv
// Searchable compacting list: packed list of signed words with search and delete.
//
// Requests enter through a queue port: drive req_* with push high; the item
// transfers at a rising edge with push high and full low. A two-entry front
// queue holds requests while the back end works, so the requester stalls only
// when that queue is full. Results leave through a second two-entry queue:
// while empty is low the oldest result sits on rsp_*, and it transfers at an
// edge with pop high. A stalled receiver only fills that queue; the back end
// then waits in its done state and requests pile up in the front queue.
// In the back end, append and write-at finish straight from the idle state,
// read-at passes through a read state, find and replace scan the entries in
// order up to the match, and delete then moves each entry behind the match
// down one place before the result is ready. The walk is set by the
// single entry memory, which gives one read and one write per cycle.
// Reset empties both queues and sets the count to zero; the entries are left
// as they are and are never read before they are written again.
`include "searchable_compacting_list_assert.svh"
module searchable_compacting_list (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [2:0]                   req_opcode,
   input  logic signed [31:0]           req_value,
   input  logic signed [31:0]           req_new_value,
   input  logic [5:0]                   req_position,
   output logic                         empty,
   input  logic                         pop,
   output logic [1:0]                   rsp_status,
   output logic [5:0]                   rsp_found_index,
   output logic signed [31:0]           rsp_read_data,
   output logic [6:0]                   rsp_entry_count
);
   import scl_pkg::*;

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);

   req_type       req_in, cmd;
   rsp_type       res, rsp;
   logic          cmd_empty, cmd_take, res_push, res_full;
   logic [CW-1:0] count;

   assign req_in = '{req_opcode, req_value, req_new_value, req_position};

   // Front: accept and hold requests.
   scl_fifo #(.WIDTH($bits(req_type))) u_front (
      .clock, .reset, .push, .push_data(req_in), .full,
      .pop(cmd_take), .pop_data(cmd), .empty(cmd_empty)
   );

   scl_engine #(.DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_engine (
      .clock, .reset, .cmd_valid(!cmd_empty), .cmd, .cmd_take,
      .res_push, .res, .res_full, .count_out(count)
   );

   // Result queue.
   scl_fifo #(.WIDTH($bits(rsp_type))) u_back (
      .clock, .reset, .push(res_push), .push_data(res), .full(res_full),
      .pop, .pop_data(rsp), .empty
   );

   assign rsp_status      = rsp.status;
   assign rsp_found_index = rsp.found_index;
   assign rsp_read_data   = rsp.read_data;
   assign rsp_entry_count = rsp.entry_count;

   `SCL_ASSERT_IMPL(a_count_range, clock, reset, count <= CW'(LIST_DEPTH))
   `SCL_ASSERT_IMPL(a_take_has_cmd, clock, reset, !(cmd_take && cmd_empty))
   `SCL_ASSERT_NEXT(a_no_blind_push, clock, reset, res_push, !(res_push && $past(res_full)))
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the searchable compacting list.
`timescale 1ns / 1ps
module testbench;
   import scl_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [2:0] req_opcode = '0;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_new_value = '0;
   logic [5:0] req_position = '0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_found_index;
   logic signed [31:0] rsp_read_data;
   logic [6:0] rsp_entry_count;

   // Shadow copy of the list and its count.
   logic [31:0] list_words [LIST_DEPTH];
   int unsigned list_count;
   rsp_type expected_results [$];
   int error_count = 0;
   int idle_cycles = 0;
   bit stimulus_done = 0;
   bit hold_off_request = 0;
   bit hold_off_active = 0;

   searchable_compacting_list i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_opcode(req_opcode), .req_value(req_value),
      .req_new_value(req_new_value), .req_position(req_position),
      .empty(empty), .pop(pop), .rsp_status(rsp_status),
      .rsp_found_index(rsp_found_index), .rsp_read_data(rsp_read_data),
      .rsp_entry_count(rsp_entry_count)
   );

   always #5 clock = ~clock;

   // Update the shadow list for one request and return the result it gives.
   function automatic rsp_type list_update(logic [2:0] op, logic [31:0] word,
                                           logic [31:0] new_word, logic [5:0] pos);
      rsp_type r;
      int hit;
      hit = -1;
      r = '0;
      if (op == OP_FIND || op == OP_REPLACE || op == OP_DELETE) begin
         for (int i = int'(list_count) - 1; i >= 0; i--)
            if (list_words[i] == word) hit = i;
      end
      case (op)
         OP_APPEND: begin
            if (list_count >= LIST_DEPTH) r.status = ST_FULL;
            else begin
               list_words[list_count] = word;
               r.found_index = 6'(list_count);
               list_count++;
            end
         end
         OP_FIND, OP_REPLACE, OP_DELETE: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else begin
               r.found_index = 6'(hit);
               if (op == OP_REPLACE) list_words[hit] = new_word;
               if (op == OP_DELETE) begin
                  for (int i = hit; i + 1 < list_count; i++)
                     list_words[i] = list_words[i + 1];
                  list_count--;
               end
            end
         end
         OP_WRITE, OP_READ: begin
            if (pos >= list_count) r.status = ST_BAD_POS;
            else begin
               r.found_index = pos;
               if (op == OP_WRITE) list_words[pos] = word;
               else r.read_data = list_words[pos];
            end
         end
         default: ;
      endcase
      r.entry_count = 7'(list_count);
      return r;
   endfunction

   // Mostly short gaps, a few long ones, often none.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Offer one request and wait for its transfer; push stays high for a
   // following request without a gap.
   task automatic send_request(logic [2:0] op, logic [31:0] word,
                               logic [31:0] new_word, logic [5:0] pos, bit gaps = 1);
      int gap;
      gap = gaps ? gap_length() : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode <= op;
      req_value <= word;
      req_new_value <= new_word;
      req_position <= pos;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_results.push_back(list_update(op, word, new_word, pos));
      @(negedge clock);
   endtask

   // Pick a word: mostly one already stored, else a random or extreme one.
   function automatic logic [31:0] pick_word();
      int roll;
      roll = $urandom_range(9);
      if (list_count > 0 && roll < 6) return list_words[$urandom_range(list_count - 1)];
      if (roll == 9) return ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff);
      if (roll == 8) return $urandom_range(3);
      return $urandom();
   endfunction

   // Stop offering and wait until every expected result has arrived.
   task automatic wait_drained();
      push <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // Extremes, every operation and each special case.
   task automatic test_directed();
      send_request(OP_READ, 0, 0, 0);
      send_request(OP_WRITE, 32'h1234, 0, 0);
      send_request(OP_FIND, 5, 0, 0);
      send_request(OP_DELETE, 5, 0, 0);
      send_request(OP_APPEND, 32'h8000_0000, 0, 0);
      send_request(OP_APPEND, 32'h7fff_ffff, 0, 0);
      send_request(OP_APPEND, 32'h8000_0000, 0, 0);
      send_request(OP_APPEND, 32'hffff_ffff, 0, 0);
      send_request(OP_FIND, 32'h8000_0000, 0, 0);
      send_request(OP_REPLACE, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_request(OP_FIND, 32'h7fff_ffff, 0, 0);
      send_request(OP_REPLACE, 32'h0, 32'h1, 0);
      send_request(OP_WRITE, 32'hffff_ffff, 0, 6'd3);
      send_request(OP_WRITE, 32'h5, 0, 6'd63);
      send_request(OP_READ, 0, 0, 6'd3);
      send_request(OP_READ, 0, 0, 6'd4);
      send_request(OP_DELETE, 32'h7fff_ffff, 0, 0);
      send_request(OP_READ, 0, 0, 6'd0);
      send_request(OP_UNUSED_A, 32'hffff_ffff, 32'hffff_ffff, 6'd63);
      send_request(OP_UNUSED_B, 0, 0, 0);
      send_request(OP_DELETE, 32'h8000_0000, 0, 0);
      send_request(OP_DELETE, 32'hffff_ffff, 0, 0);
      send_request(OP_DELETE, 32'h7fff_ffff, 0, 0);
   endtask

   // Fill to the limit with the receiver held off, then overflow and drain.
   task automatic test_full_list();
      hold_off_request = 1;
      while (list_count < LIST_DEPTH) send_request(OP_APPEND, $urandom(), 0, 0, 0);
      send_request(OP_APPEND, 32'h1, 0, 0);
      send_request(OP_READ, 0, 0, 6'd63);
      send_request(OP_WRITE, 32'h0, 0, 6'd63);
      send_request(OP_DELETE, list_words[0], 0, 0);
      send_request(OP_DELETE, list_words[LIST_DEPTH - 2], 0, 0);
      hold_off_request = 0;
      wait_drained();
      while (list_count > 0) send_request(OP_DELETE, list_words[$urandom_range(list_count - 1)], 0, 0);
   endtask

   // Random mix, with the list size swept between empty and full.
   task automatic test_random_mix(int items);
      logic [2:0] op;
      int bias;
      for (int n = 0; n < items; n++) begin
         bias = (n / 200) % 2;
         case ($urandom_range(9))
            0, 1: op = OP_APPEND;
            2: op = OP_FIND;
            3: op = OP_REPLACE;
            4: op = bias ? OP_APPEND : OP_DELETE;
            5: op = OP_DELETE;
            6: op = OP_WRITE;
            7: op = OP_READ;
            8: op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : OP_READ;
            default: op = bias ? OP_APPEND : OP_FIND;
         endcase
         send_request(op, pick_word(), $urandom(),
                      (list_count > 0 && $urandom_range(3) != 0)
                         ? 6'($urandom_range(list_count - 1)) : 6'($urandom()));
         if (n == items / 2) wait_drained();
      end
   endtask

   // Receiver: random pops, plus one long hold-off when asked.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request && !hold_off_active) begin
            hold_off_active = 1;
            pop <= 1'b0;
            repeat (400) @(negedge clock);
         end
         gap = gap_length();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         @(negedge clock);
      end
   end

   // Check each transferred result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status %0d index %0d data %0h count %0d",
                     $time, rsp_status, rsp_found_index, rsp_read_data, rsp_entry_count);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_found_index !== want.found_index) begin
               $display("%0t: found_index expected %0d actual %0d",
                        $time, want.found_index, rsp_found_index);
               error_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data expected %0h actual %0h",
                        $time, want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
      list_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_list();
      test_random_mix(1600);
      stimulus_done = 1;
      wait_drained();
      repeat (200) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end
endmodule
